// ===== sv/wcbf_pkg.sv =====
// ----------------------------------------------------------------------------
// wcbf_pkg: shared types and constants of the WebM cluster/block framer
// Holds the action codes, the command word passed from the front end to the
// back end, the serializer phases and the fixed EBML header bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package wcbf_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int QDEPTH          = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;
    localparam logic [15:0] SPAN_RESET = 16'd5000;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN   = 1'd1;

    localparam int CLUSTER_HDR_LEN = 14;

    localparam logic [7:0] ID_BLOCK    = 8'hA3;
    localparam logic [7:0] ID_TIME     = 8'hE7;
    localparam logic [7:0] TRACK_VIDEO = 8'h81;
    localparam logic [7:0] TRACK_AUDIO = 8'h82;
    localparam logic [7:0] FLAG_KEY    = 8'h80;
    localparam logic [7:0] FLAG_NONE   = 8'h00;
    localparam logic [7:0] VINT_MARK1  = 8'h80;

    typedef enum logic [1:0] {
        ACT_VIDEO   = 2'd0,
        ACT_AUDIO   = 2'd1,
        ACT_PAYLOAD = 2'd2,
        ACT_FLUSH   = 2'd3
    } t_action;

    typedef enum logic {
        K_BLOCK   = 1'b0,
        K_PAYLOAD = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        PH_CLUSTER,
        PH_TIME,
        PH_BLKID,
        PH_SIZE,
        PH_TRACK,
        PH_RELHI,
        PH_RELLO,
        PH_FLAGS,
        PH_PAYLOAD
    } t_phase;

    // One queued unit of work for the serializer.
    typedef struct packed {
        t_kind       kind;
        logic        open;       // emit a cluster header first
        logic        audio;
        logic        key;
        logic [31:0] tm;         // cluster timestamp value
        logic [2:0]  tcnt;       // bytes of the timestamp value
        logic [31:0] size_word;  // block size with the VINT marker bit set
        logic [2:0]  scnt;       // bytes of the size VINT
        logic [15:0] rel;        // block timestamp relative to the cluster
        logic [7:0]  pbyte;
    } t_cmd;

    // Byte sh (counted from the least significant end) of a 32-bit word.
    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [2:0] sh);
        logic [7:0] b;
        case (sh)
            3'd0:    b = w[7:0];
            3'd1:    b = w[15:8];
            3'd2:    b = w[23:16];
            3'd3:    b = w[31:24];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Fixed part of a cluster opening: ID, unknown size, Timestamp ID and
    // the one-byte VINT that sizes the timestamp value.
    function automatic logic [7:0] cluster_hdr_byte(input logic [3:0] idx,
                                                    input logic [2:0] tcnt);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h1F;
            4'd1:    b = 8'h43;
            4'd2:    b = 8'hB6;
            4'd3:    b = 8'h75;
            4'd4:    b = 8'h01;
            4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: b = 8'hFF;
            4'd12:   b = ID_TIME;
            4'd13:   b = VINT_MARK1 | {5'd0, tcnt};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/wcbf_front.sv =====
// ----------------------------------------------------------------------------
// wcbf_front: input classification and cluster bookkeeping
// Accepts one input beat per cycle unless the queue is full, decides whether
// a cluster opens, keeps cluster and config registers, and queues a command.
// ----------------------------------------------------------------------------
`default_nettype none

module wcbf_front
    import wcbf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire  [1:0]             i_action,
    input  wire  [31:0]            i_time,
    input  wire  [LENGTH_BITS-1:0] i_len,
    input  wire                    i_key,
    input  wire  [7:0]             i_pbyte,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_push,
    output t_cmd                   o_cmd,
    input  wire                    i_full
);

    logic        r_enable, n_enable;
    logic [15:0] r_span, n_span;
    logic        r_open, n_open;
    logic [31:0] r_start, n_start;

    t_action     act;
    logic        accept;
    logic [31:0] diff;
    logic        span_hit;
    logic        open_new;
    logic [31:0] size;
    logic [2:0]  scnt;
    logic [31:0] marker;
    logic [2:0]  tcnt;

    assign o_ready     = !i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign act         = t_action'(i_action);

    always_comb begin
        diff     = i_time - r_start;
        span_hit = diff >= {16'd0, r_span};
        open_new = (act == ACT_VIDEO) && r_enable && (!r_open || i_key || span_hit);

        size = 32'(i_len) + 32'd4;
        // Fewest VINT bytes whose data bits are not all ones.
        if (size < 32'd127) begin
            scnt = 3'd1;
        end else if (size < 32'd16383) begin
            scnt = 3'd2;
        end else if (size < 32'd2097151) begin
            scnt = 3'd3;
        end else begin
            scnt = 3'd4;
        end
        case (scnt)
            3'd1:    marker = 32'h0000_0080;
            3'd2:    marker = 32'h0000_4000;
            3'd3:    marker = 32'h0020_0000;
            default: marker = 32'h1000_0000;
        endcase

        if (i_time < 32'h80) begin
            tcnt = 3'd1;
        end else if (i_time < 32'h4000) begin
            tcnt = 3'd2;
        end else if (i_time < 32'h20_0000) begin
            tcnt = 3'd3;
        end else if (i_time < 32'h1000_0000) begin
            tcnt = 3'd4;
        end else begin
            tcnt = 3'd5;
        end

        o_cmd.kind      = (act == ACT_PAYLOAD) ? K_PAYLOAD : K_BLOCK;
        o_cmd.open      = open_new;
        o_cmd.audio     = (act == ACT_AUDIO);
        o_cmd.key       = i_key;
        o_cmd.tm        = i_time;
        o_cmd.tcnt      = tcnt;
        o_cmd.size_word = size | marker;
        o_cmd.scnt      = scnt;
        // A new cluster starts at this frame, so its offset is zero.
        o_cmd.rel       = open_new ? 16'd0 : diff[15:0];
        o_cmd.pbyte     = i_pbyte;

        o_push = 1'b0;
        case (act)
            ACT_VIDEO:   o_push = accept && r_enable;
            ACT_AUDIO:   o_push = accept && r_enable && r_open;
            ACT_PAYLOAD: o_push = accept;
            default:     o_push = 1'b0;
        endcase
    end

    always_comb begin
        n_enable = r_enable;
        n_span   = r_span;
        n_open   = r_open;
        n_start  = r_start;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE: n_enable = i_cfg_data[0];
                CFG_SPAN:   n_span   = i_cfg_data[15:0];
                default:    n_span   = r_span;
            endcase
        end
        if (accept) begin
            if (open_new) begin
                n_open  = 1'b1;
                n_start = i_time;
            end else if (act == ACT_FLUSH) begin
                n_open = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_span   <= SPAN_RESET;
            r_open   <= 1'b0;
            r_start  <= '0;
        end else begin
            r_enable <= n_enable;
            r_span   <= n_span;
            r_open   <= n_open;
            r_start  <= n_start;
        end
    end

endmodule

`default_nettype wire

// ===== sv/wcbf_queue.sv =====
// ----------------------------------------------------------------------------
// wcbf_queue: command queue between front end and back end
// A small first-in first-out buffer in flip-flops; the head is visible to the
// back end without a read delay.
// ----------------------------------------------------------------------------
`default_nettype none

module wcbf_queue
    import wcbf_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    input  wire   i_pop,
    output t_cmd  o_head,
    output logic  o_empty
);

    localparam int PtrW = $clog2(QDEPTH);
    localparam int CntW = $clog2(QDEPTH + 1);

    t_cmd            r_mem [QDEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CntW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + PtrW'(1) : r_wr;
        n_rd  = i_pop  ? r_rd + PtrW'(1) : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CntW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/wcbf_back.sv =====
// ----------------------------------------------------------------------------
// wcbf_back: byte serializer
// Walks the head command through its phases one byte per cycle, unless the
// output stalls, and drives the registered output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module wcbf_back
    import wcbf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_head,
    input  wire         i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [7:0]  o_byte,
    output logic        o_is_payload,
    output logic        o_last
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic        r_fresh, n_fresh;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_obyte;
    logic        r_opay;
    logic        r_olast;

    t_phase      ph;
    t_phase      nph;
    logic [3:0]  idx;
    logic [7:0]  cur_byte;
    logic        cur_pay;
    logic        ph_end;
    logic        item_end;
    logic        advance;

    assign advance      = !i_empty && (!r_ovalid || i_ready);
    assign o_pop        = advance && item_end;
    assign o_valid      = r_ovalid;
    assign o_byte       = r_obyte;
    assign o_is_payload = r_opay;
    assign o_last       = r_olast;

    always_comb begin
        // At the start of a command the phase comes from the command itself.
        if (r_fresh) begin
            if (i_head.kind == K_PAYLOAD) begin
                ph = PH_PAYLOAD;
            end else if (i_head.open) begin
                ph = PH_CLUSTER;
            end else begin
                ph = PH_BLKID;
            end
            idx = '0;
        end else begin
            ph  = r_phase;
            idx = r_idx;
        end

        cur_byte = 8'h00;
        cur_pay  = 1'b0;
        ph_end   = 1'b0;
        item_end = 1'b0;
        nph      = ph;
        case (ph)
            PH_CLUSTER: begin
                cur_byte = cluster_hdr_byte(idx, i_head.tcnt);
                ph_end   = (idx == 4'(CLUSTER_HDR_LEN - 1));
                nph      = PH_TIME;
            end
            PH_TIME: begin
                cur_byte = be_byte(i_head.tm, i_head.tcnt - 3'd1 - idx[2:0]);
                ph_end   = (idx[2:0] == i_head.tcnt - 3'd1);
                nph      = PH_BLKID;
            end
            PH_BLKID: begin
                cur_byte = ID_BLOCK;
                ph_end   = 1'b1;
                nph      = PH_SIZE;
            end
            PH_SIZE: begin
                cur_byte = be_byte(i_head.size_word, i_head.scnt - 3'd1 - idx[2:0]);
                ph_end   = (idx[2:0] == i_head.scnt - 3'd1);
                nph      = PH_TRACK;
            end
            PH_TRACK: begin
                cur_byte = i_head.audio ? TRACK_AUDIO : TRACK_VIDEO;
                ph_end   = 1'b1;
                nph      = PH_RELHI;
            end
            PH_RELHI: begin
                cur_byte = i_head.rel[15:8];
                ph_end   = 1'b1;
                nph      = PH_RELLO;
            end
            PH_RELLO: begin
                cur_byte = i_head.rel[7:0];
                ph_end   = 1'b1;
                nph      = PH_FLAGS;
            end
            PH_FLAGS: begin
                cur_byte = (i_head.key && !i_head.audio) ? FLAG_KEY : FLAG_NONE;
                ph_end   = 1'b1;
                item_end = 1'b1;
            end
            PH_PAYLOAD: begin
                cur_byte = i_head.pbyte;
                cur_pay  = 1'b1;
                ph_end   = 1'b1;
                item_end = 1'b1;
            end
            default: begin
                item_end = 1'b1;
            end
        endcase

        n_phase  = r_phase;
        n_idx    = r_idx;
        n_fresh  = r_fresh;
        n_ovalid = r_ovalid;
        if (advance) begin
            n_ovalid = 1'b1;
            if (item_end) begin
                n_fresh = 1'b1;
            end else begin
                n_fresh = 1'b0;
                n_phase = ph_end ? nph : ph;
                n_idx   = ph_end ? 4'd0 : idx + 4'd1;
            end
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CLUSTER;
            r_idx    <= '0;
            r_fresh  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_fresh  <= n_fresh;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_obyte <= cur_byte;
            r_opay  <= cur_pay;
            r_olast <= item_end;
        end
    end

endmodule

`default_nettype wire

// ===== sv/webm_cluster_block_framer.sv =====
// Payload-byte beats can arrive every cycle unless the command queue is full
// and leave at one byte per cycle unless the output stalls; the output beat
// for an input beat passes through the command queue and then the output
// register. A video frame has 6 to 9 bytes in its SimpleBlock header, plus 15
// to 19 more when it opens a cluster (28 at most); an audio frame has 6 to 9.
// The serializer in the back end emits one byte per clock unless the output
// stalls, so a frame's header bytes set the output time; the front end keeps
// taking beats back to back until the four-entry command queue is full.
// Flushes and dropped frames are taken as input beats and give no output.
// ----------------------------------------------------------------------------
// webm_cluster_block_framer: live WebM cluster and SimpleBlock framer
// Frames frame descriptors and payload bytes into a WebM byte stream with
// unknown-size clusters, a front end and a back end joined by a queue.
// ----------------------------------------------------------------------------
`default_nettype none

module webm_cluster_block_framer
    import wcbf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    localparam int DataW = ((40 + LENGTH_BITS + 7) / 8) * 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    // [31:0] time_ms, [LENGTH_BITS+31:32] frame_length,
    // [LENGTH_BITS+39:LENGTH_BITS+32] payload_byte, zero padding above
    input  wire  [DataW-1:0]      i_s_tdata,
    // [1:0] action, [2] keyframe
    input  wire  [2:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    // [7:0] out_byte
    output logic [7:0]            o_m_tdata,
    // [0] is_payload
    output logic [0:0]            o_m_tuser,
    output logic                  o_m_tlast,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_head;

    wcbf_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_action    (i_s_tuser[1:0]),
        .i_time      (i_s_tdata[31:0]),
        .i_len       (i_s_tdata[LENGTH_BITS+31:32]),
        .i_key       (i_s_tuser[2]),
        .i_pbyte     (i_s_tdata[LENGTH_BITS+39:LENGTH_BITS+32]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (q_push),
        .o_cmd       (q_in),
        .i_full      (q_full)
    );

    wcbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    wcbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_empty      (q_empty),
        .o_pop        (q_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (o_m_tdata),
        .o_is_payload (o_m_tuser[0]),
        .o_last       (o_m_tlast)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command queue read while empty");

    a_payload_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tlast)
        else $error("payload byte not marked as last of its run");

    a_payload_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && q_empty && !o_m_tvalid) |=> ##1 o_m_tvalid)
        else $error("queued command did not reach the output");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_webm_cluster_block_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_webm_cluster_block_framer: self-checking bench for the WebM framer
// Feeds frame descriptors, payload bytes and flushes through the input
// stream, predicts every output byte with its payload and last flags, and
// compares the output stream beat by beat under random idle and stall
// patterns and several register settings.
// ----------------------------------------------------------------------------

module tb_webm_cluster_block_framer;
    import wcbf_pkg::*;

    localparam int DATA_W          = ((40 + LENGTH_BITS_DEF + 7) / 8) * 8;
    localparam int SETTLE_CYCLES   = 20;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int MAX_REPORTS     = 20;
    localparam logic [31:0] CLUSTER_ID = 32'h1F43B675;

    typedef struct packed {
        t_action                    act;
        logic                       key;
        logic [31:0]                tm;
        logic [LENGTH_BITS_DEF-1:0] flen;
        logic [7:0]                 pb;
    } t_frame_item;

    typedef struct packed {
        logic [7:0] data;
        logic       pay;
        logic       last;
    } t_stream_byte;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic [2:0]            s_tuser = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [7:0]            m_tdata;
    wire  [0:0]            m_tuser;
    wire                   m_tlast;
    wire                   cfg_ready;

    webm_cluster_block_framer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_frame_item  pending_items[$];
    t_stream_byte expected_bytes[$];

    // Predictor copy of the registers and the cluster state.
    logic        model_en = 1'b0;
    logic [15:0] model_span = SPAN_RESET;
    logic        clus_open = 1'b0;
    logic [31:0] clus_start = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int beats_in = 0;
    int bytes_out = 0;
    int clusters_opened = 0;
    int blocks_framed = 0;
    int frames_ignored = 0;
    int stall_cycles = 0;
    logic [31:0] clock_ms = '0;

    // ------------------------------------------------------------------
    // Stream prediction
    // ------------------------------------------------------------------
    function automatic void push_hdr(input logic [7:0] b);
        t_stream_byte w;
        w.data = b;
        w.pay  = 1'b0;
        w.last = 1'b0;
        expected_bytes.push_back(w);
    endfunction

    function automatic void push_be(input logic [63:0] v, input int cnt);
        logic [63:0] sh;
        for (int i = cnt; i > 0; i--) begin
            sh = v >> (8 * (i - 1));
            push_hdr(sh[7:0]);
        end
    endfunction

    // Fewest bytes whose data bits are not all ones.
    function automatic void push_vint(input logic [63:0] size);
        int n;
        n = 1;
        while (n < 8 && size >= ((64'd1 << (7 * n)) - 64'd1))
            n++;
        push_be(size | (64'd1 << (7 * n)), n);
    endfunction

    function automatic int stamp_bytes(input logic [31:0] t);
        if (t < 32'h80)       return 1;
        if (t < 32'h4000)     return 2;
        if (t < 32'h200000)   return 3;
        if (t < 32'h10000000) return 4;
        return 5;
    endfunction

    function automatic void start_cluster(input logic [31:0] t);
        int cnt;
        cnt = stamp_bytes(t);
        clus_start = t;
        clus_open = 1'b1;
        clusters_opened++;
        push_be({32'd0, CLUSTER_ID}, 4);
        push_hdr(8'h01);
        repeat (7) push_hdr(8'hFF);
        push_hdr(ID_TIME);
        push_vint(64'(cnt));
        push_be({32'd0, t}, cnt);
    endfunction

    function automatic void push_block(input logic [7:0] track, input logic [31:0] t,
                                       input logic [LENGTH_BITS_DEF-1:0] len,
                                       input logic [7:0] flags);
        logic [31:0] rel;
        rel = t - clus_start;
        blocks_framed++;
        push_hdr(ID_BLOCK);
        push_vint({{(64 - LENGTH_BITS_DEF){1'b0}}, len} + 64'd4);
        push_hdr(track);
        push_hdr(rel[15:8]);
        push_hdr(rel[7:0]);
        push_hdr(flags);
    endfunction

    function automatic void predict_stream_bytes(input t_frame_item it);
        int           first;
        logic [31:0]  dt;
        t_stream_byte w;
        first = expected_bytes.size();
        case (it.act)
            ACT_VIDEO: begin
                if (model_en) begin
                    dt = it.tm - clus_start;
                    if (!clus_open || it.key || dt >= {16'd0, model_span})
                        start_cluster(it.tm);
                    push_block(TRACK_VIDEO, it.tm, it.flen, it.key ? FLAG_KEY : FLAG_NONE);
                end else begin
                    frames_ignored++;
                end
            end
            ACT_AUDIO: begin
                if (model_en && clus_open)
                    push_block(TRACK_AUDIO, it.tm, it.flen, FLAG_NONE);
                else
                    frames_ignored++;
            end
            ACT_PAYLOAD: begin
                w.data = it.pb;
                w.pay  = 1'b1;
                w.last = 1'b0;
                expected_bytes.push_back(w);
            end
            default: begin
                clus_open = 1'b0;
            end
        endcase
        if (expected_bytes.size() > first) begin
            w = expected_bytes.pop_back();
            w.last = 1'b1;
            expected_bytes.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: holds a beat until it is taken, then moves on.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_stream_bytes(pending_items.pop_front());
                beats_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {pending_items[0].pb, pending_items[0].flen,
                                 pending_items[0].tm};
                    s_tuser  <= {pending_items[0].key, pending_items[0].act};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor
    // ------------------------------------------------------------------
    t_stream_byte want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                bytes_out++;
                if (expected_bytes.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: extra beat: expected none, got %02h pay %0b last %0b",
                                 $time, m_tdata, m_tuser[0], m_tlast);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data || m_tuser[0] !== want.pay ||
                        m_tlast !== want.last) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                     $time, want.data, want.pay, want.last,
                                     m_tdata, m_tuser[0], m_tlast);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no beat on any channel for too long ends the run.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_CYCLES) begin
                $display("%0t: timeout, no beat accepted for %0d cycles", $time, stall_cycles);
                $display("== FAIL ==");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic t_frame_item mk_item(input t_action act, input logic [31:0] tm,
                                            input logic [31:0] flen, input logic key,
                                            input logic [7:0] pb);
        t_frame_item it;
        it.act  = act;
        it.tm   = tm;
        it.flen = flen[LENGTH_BITS_DEF-1:0];
        it.key  = key;
        it.pb   = pb;
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ENABLE)
            model_en = val[0];
        else
            model_span = val;
    endtask

    // Waits until every beat is taken and every byte has come out, then lets
    // the design settle before returning.
    task automatic drain();
        while (pending_items.size() != 0 || expected_bytes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly frames followed by some of their payload bytes, with rising
    // timestamps near the span edge; the rest is flushes and noise.
    task automatic gen_traffic(input int target, input int span_hint);
        int          made;
        int          pick;
        int          npay;
        int          hint;
        logic        audio;
        logic        key;
        logic [31:0] flen;
        logic [31:0] tm;
        t_frame_item it;
        made = 0;
        hint = (span_hint < 1) ? 1 : span_hint;
        while (made < target) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                it.act  = t_action'($urandom_range(3));
                it.tm   = $urandom;
                it.flen = LENGTH_BITS_DEF'($urandom);
                it.key  = 1'($urandom_range(1));
                it.pb   = 8'($urandom);
                pending_items.push_back(it);
                made++;
            end else if (pick < 13) begin
                pending_items.push_back(mk_item(ACT_FLUSH, $urandom, $urandom,
                                                1'($urandom_range(1)), 8'($urandom)));
                made++;
            end else begin
                pick = $urandom_range(9);
                if (pick < 5)
                    clock_ms += $urandom_range(0, hint / 3);
                else if (pick < 8)
                    clock_ms += hint - 1 + $urandom_range(0, 2);
                else if (pick == 8)
                    clock_ms += $urandom_range(0, 3);
                else
                    clock_ms += $urandom;
                audio = ($urandom_range(2) == 0);
                key   = !audio && ($urandom_range(3) == 0);
                flen  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 130);
                tm    = audio ? clock_ms - 5 + $urandom_range(0, 10) : clock_ms;
                pending_items.push_back(mk_item(audio ? ACT_AUDIO : ACT_VIDEO, tm, flen,
                                                key, 8'($urandom)));
                made++;
                npay = $urandom_range(0, (flen < 5) ? flen : 5);
                repeat (npay)
                    pending_items.push_back(mk_item(ACT_PAYLOAD, $urandom, $urandom,
                                                    1'($urandom_range(1)), 8'($urandom)));
                made += npay;
            end
        end
    endtask

    int          ph;
    int          ph_span[5] = '{1, 65535, 0, 300, 0};
    logic        ph_en[5] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    int          ph_send_idle[5] = '{0, 48, 0, 14, 14};
    int          ph_recv_stall[5] = '{0, 0, 48, 14, 14};
    logic [15:0] en_word;

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset the stream is disabled: frames vanish, payload passes.
        @(negedge i_clk);
        pending_items.push_back(mk_item(ACT_VIDEO, 32'd100, 32'd10, 1'b1, 8'h11));
        pending_items.push_back(mk_item(ACT_AUDIO, 32'd100, 32'd10, 1'b0, 8'h22));
        pending_items.push_back(mk_item(ACT_PAYLOAD, 32'd0, 32'd0, 1'b0, 8'h3C));
        pending_items.push_back(mk_item(ACT_FLUSH, 32'd0, 32'd0, 1'b0, 8'h00));
        drain();
        write_reg(CFG_ENABLE, 16'h0001);

        @(negedge i_clk);
        // Audio before any cluster is dropped; the first video frame opens one.
        pending_items.push_back(mk_item(ACT_AUDIO, 32'd0, 32'd9, 1'b0, 8'h00));
        pending_items.push_back(mk_item(ACT_VIDEO, 32'd0, 32'd0, 1'b0, 8'h00));
        pending_items.push_back(mk_item(ACT_PAYLOAD, 32'd0, 32'd0, 1'b0, 8'h00));
        pending_items.push_back(mk_item(ACT_PAYLOAD, 32'hFFFFFFFF, 32'hFFFFFF, 1'b1, 8'hFF));
        // Block sizes on both sides of the one- and two-byte limits, and past the three-byte limit.
        pending_items.push_back(mk_item(ACT_AUDIO, 32'd5, 32'd122, 1'b0, 8'h00));
        pending_items.push_back(mk_item(ACT_AUDIO, 32'd6, 32'd123, 1'b0, 8'h00));
        pending_items.push_back(mk_item(ACT_VIDEO, 32'd4999, 32'd16379, 1'b0, 8'h00));
        // Exactly one span after the cluster start opens a new cluster.
        pending_items.push_back(mk_item(ACT_VIDEO, 32'd5000, 32'd16378, 1'b0, 8'h00));
        // Relative timestamp wraps past 16 bits.
        pending_items.push_back(mk_item(ACT_AUDIO, 32'd5000 + 32'h12345, 32'h1FFFFB,
                                        1'b0, 8'h00));
        // Keyframes at every cluster timestamp width boundary.
        pending_items.push_back(mk_item(ACT_VIDEO, 32'h7F, 32'hFFFFFF, 1'b1, 8'h00));
        pending_items.push_back(mk_item(ACT_VIDEO, 32'h80, 32'd1, 1'b1, 8'h00));
        pending_items.push_back(mk_item(ACT_VIDEO, 32'h3FFF, 32'd2, 1'b1, 8'h00));
        pending_items.push_back(mk_item(ACT_VIDEO, 32'h4000, 32'd3, 1'b1, 8'h00));
        pending_items.push_back(mk_item(ACT_VIDEO, 32'h1FFFFF, 32'd4, 1'b1, 8'h00));
        pending_items.push_back(mk_item(ACT_VIDEO, 32'h200000, 32'd5, 1'b1, 8'h00));
        pending_items.push_back(mk_item(ACT_VIDEO, 32'h0FFFFFFF, 32'd6, 1'b1, 8'h00));
        pending_items.push_back(mk_item(ACT_VIDEO, 32'h10000000, 32'd7, 1'b1, 8'h00));
        pending_items.push_back(mk_item(ACT_VIDEO, 32'hFFFFFFFF, 32'hFFFFFF, 1'b1, 8'h00));
        // Time wraps through zero but stays inside the span.
        pending_items.push_back(mk_item(ACT_VIDEO, 32'h10, 32'd8, 1'b0, 8'h00));
        // A flush closes the cluster, so audio drops and video reopens.
        pending_items.push_back(mk_item(ACT_FLUSH, 32'hFFFFFFFF, 32'hFFFFFF, 1'b1, 8'hFF));
        pending_items.push_back(mk_item(ACT_AUDIO, 32'h20, 32'd1, 1'b0, 8'h00));
        pending_items.push_back(mk_item(ACT_VIDEO, 32'h30, 32'd1, 1'b0, 8'h00));
        pending_items.push_back(mk_item(ACT_PAYLOAD, 32'd0, 32'd0, 1'b0, 8'hA5));
        pending_items.push_back(mk_item(ACT_FLUSH, 32'd0, 32'd0, 1'b0, 8'h00));
        pending_items.push_back(mk_item(ACT_PAYLOAD, 32'd0, 32'd0, 1'b0, 8'h5A));
        drain();

        ph_span[4] = $urandom_range(50, 3000);
        clock_ms = $urandom;
        for (ph = 0; ph < 5; ph++) begin
            en_word = 16'($urandom);
            en_word[0] = ph_en[ph];
            write_reg(CFG_ENABLE, en_word);
            write_reg(CFG_SPAN, 16'(ph_span[ph]));
            send_idle_pct  = ph_send_idle[ph];
            recv_stall_pct = ph_recv_stall[ph];
            @(negedge i_clk);
            gen_traffic(28, ph_span[ph]);
            drain();
        end

        $display("Sent %0d input beats and checked %0d output beats over seven settings,",
                 beats_in, bytes_out);
        $display("with %0d clusters opened, %0d blocks framed and %0d frames dropped.",
                 clusters_opened, blocks_framed, frames_ignored);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d output beats were wrong or unexpected", err_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
